FILE: rtl/vfa_pkg.sv
`default_nettype none
package vfa_pkg;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
  localparam logic [OP_W-1:0] OP_SCALE = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
  localparam logic [OP_W-1:0] OP_NORM  = 4'd5;
  localparam logic [OP_W-1:0] OP_DOT   = 4'd6;
  localparam logic [OP_W-1:0] OP_CROSS = 4'd7;
  localparam logic [OP_W-1:0] OP_LEN   = 4'd8;
  localparam logic [OP_W-1:0] OP_LENSQ = 4'd9;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // queue between the front and the back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // one quotient or root bit per pipe step
  localparam int ROOT_W = 32;
  localparam int QUO_W  = 32;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            dz;
  } cls_t;

  typedef struct packed {
    cls_t             cls;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [31:0]      f;
  } item_t;

  typedef struct packed {
    logic [2:0][31:0] r;
    logic [31:0]      s;
    logic             dz;
    logic             sat;
  } res_t;

  // carried alongside the root pipe
  typedef struct packed {
    cls_t             cls;
    res_t             byp;
    logic [2:0][31:0] nmag;
    logic [2:0]       neg;
    logic [31:0]      fmag;
  } side_t;

  // carried alongside the divide pipe
  typedef struct packed {
    cls_t        cls;
    res_t        byp;
    logic [31:0] root;
    logic [2:0]  neg;
  } dside_t;

endpackage
`default_nettype wire

FILE: rtl/vec3_fixed_point_alu_core.sv
`default_nettype none
// Channel  Dir  tdata (low bit up)                        tuser (low bit up)
// s_*      in   ax, ay, az, bx, by_comp, bz, factor (224)  opcode (4)
// m_*      out  rx, ry, rz, rscalar (128)                  div_zero, saturated
//
// One word accepted per cycle while the queue has room; every word passes through the
// 32-step root pipe and then the divide pipe (a set-up step and 32 quotient steps),
// so results stay in order.
// Reset (rst, synchronous) empties the front register, the queue and the pipe.
// A stall on m_* freezes the pipe; the four-word queue lets the front keep
// taking words until it fills.
module vec3_fixed_point_alu_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [223:0] s_tdata,   // ax, ay, az, bx, by_comp, bz, factor
  input  wire logic [3:0]   s_tuser,   // opcode
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,   // rx, ry, rz, rscalar
  output logic [1:0]        m_tuser    // div_zero, saturated
);

  logic           f_valid;
  logic           q_ready;
  vfa_pkg::item_t f_item;
  logic           b_valid;
  logic           b_ready;
  vfa_pkg::item_t b_item;
  vfa_pkg::res_t  res;

  vfa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .in_op     (s_tuser),
    .out_valid (f_valid),
    .out_ready (q_ready),
    .out_item  (f_item)
  );

  vfa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (q_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item)
  );

  vfa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_item   (b_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {res.s, res.r[2], res.r[1], res.r[0]};
  assign m_tuser = {res.sat, res.dz};

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("div_zero and saturated raised together");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 128'd0))
    else $error("zero-divide result carries data");

  a_front_blocks: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> (f_valid && !q_ready))
    else $error("front refused a word with room to hold it");

endmodule
`default_nettype wire

FILE: rtl/vfa_front.sv
`default_nettype none
module vfa_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [223:0]         in_data,
  input  wire logic [3:0]           in_op,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output vfa_pkg::item_t            out_item
);

  logic           held;
  vfa_pkg::item_t item;
  vfa_pkg::item_t item_next;
  logic           accept;

  assign in_ready  = !held || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = held;
  assign out_item  = item;

  // classify: flag the zero divisor and the zero vector up front
  always_comb begin
    item_next.a[0] = in_data[31:0];
    item_next.a[1] = in_data[63:32];
    item_next.a[2] = in_data[95:64];
    item_next.b[0] = in_data[127:96];
    item_next.b[1] = in_data[159:128];
    item_next.b[2] = in_data[191:160];
    item_next.f    = in_data[223:192];
    item_next.cls.op = in_op;
    item_next.cls.dz =
      ((in_op == vfa_pkg::OP_DIV) && (in_data[223:192] == 32'd0)) ||
      ((in_op == vfa_pkg::OP_NORM) && (in_data[95:0] == 96'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (out_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vfa_fifo.sv
`default_nettype none
module vfa_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire vfa_pkg::item_t in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output vfa_pkg::item_t      out_item
);

  vfa_pkg::item_t              slots [vfa_pkg::QDEPTH];
  logic [vfa_pkg::QPTR_W-1:0]  wr_ptr;
  logic [vfa_pkg::QPTR_W-1:0]  rd_ptr;
  logic [vfa_pkg::QPTR_W:0]    count;
  logic                        push;
  logic                        pop;

  assign in_ready  = (count != (vfa_pkg::QPTR_W+1)'(vfa_pkg::QDEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vfa_sqrt.sv
`default_nettype none
module vfa_sqrt (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           in_valid,
  input  wire logic [63:0]    in_rad,
  input  wire vfa_pkg::side_t in_side,
  output logic                out_valid,
  output logic [31:0]         out_root,
  output vfa_pkg::side_t      out_side
);

  localparam int N = vfa_pkg::ROOT_W;

  logic           vld  [N+1];
  logic [33:0]    rem  [N+1];
  logic [31:0]    root [N+1];
  logic [63:0]    rad  [N+1];
  vfa_pkg::side_t sd   [N+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = in_rad;
  assign sd[0]   = in_side;

  // one root bit per step: bring down two radicand bits, try 4r+1
  for (genvar k = 0; k < N; k++) begin : g_step
    logic [35:0] tmp;
    logic [35:0] trial;
    logic        ge;

    assign tmp   = {rem[k], rad[k][63:62]};
    assign trial = {2'b00, root[k], 2'b01};
    assign ge    = (tmp >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1]  <= ge ? 34'(tmp - trial) : tmp[33:0];
        root[k+1] <= {root[k][30:0], ge};
        rad[k+1]  <= {rad[k][61:0], 2'b00};
        sd[k+1]   <= sd[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root  = root[N];
  assign out_side  = sd[N];

endmodule
`default_nettype wire

FILE: rtl/vfa_div.sv
`default_nettype none
module vfa_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           in_valid,
  input  wire logic [31:0]    in_root,
  input  wire vfa_pkg::side_t in_side,
  output logic                out_valid,
  output logic [2:0][31:0]    out_quo,
  output logic [2:0]          out_big,
  output vfa_pkg::dside_t     out_side
);

  localparam int N = vfa_pkg::QUO_W;

  logic            vld [N+1];
  logic [31:0]     dv  [N+1];
  logic [2:0]      big [N+1];
  vfa_pkg::dside_t sd  [N+1];
  logic [2:0][31:0] rem [N+1];
  logic [2:0][31:0] nl  [N+1];
  logic [2:0][31:0] quo [N+1];

  logic [31:0] d_sel;

  assign d_sel = (in_side.cls.op == vfa_pkg::OP_NORM) ? in_root : in_side.fmag;

  // set-up step: quotients of 2^32 or more are caught here and saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0]       <= d_sel;
      sd[0].cls   <= in_side.cls;
      sd[0].byp   <= in_side.byp;
      sd[0].root  <= in_root;
      sd[0].neg   <= in_side.neg;
      for (int l = 0; l < 3; l++) begin
        big[0][l] <= ({16'd0, in_side.nmag[l]} >= {d_sel, 16'd0});
        rem[0][l] <= {16'd0, in_side.nmag[l][31:16]};
        nl[0][l]  <= {in_side.nmag[l][15:0], 16'd0};
        quo[0][l] <= '0;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [2:0][32:0] t;
    logic [2:0]       ge;

    for (genvar l = 0; l < 3; l++) begin : g_lane
      assign t[l]  = {rem[k][l], nl[k][l][31]};
      assign ge[l] = (t[l] >= {1'b0, dv[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k+1]  <= dv[k];
        big[k+1] <= big[k];
        sd[k+1]  <= sd[k];
        for (int l = 0; l < 3; l++) begin
          rem[k+1][l] <= ge[l] ? 32'(t[l] - {1'b0, dv[k]}) : t[l][31:0];
          nl[k+1][l]  <= {nl[k][l][30:0], 1'b0};
          quo[k+1][l] <= {quo[k][l][30:0], ge[l]};
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign out_quo   = quo[N];
  assign out_big   = big[N];
  assign out_side  = sd[N];

endmodule
`default_nettype wire

FILE: rtl/vfa_back.sv
`default_nettype none
module vfa_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire vfa_pkg::item_t in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output vfa_pkg::res_t       out_res
);

  localparam logic signed [49:0] WIDE_MAX = 50'sd2147483647;
  localparam logic signed [49:0] WIDE_MIN = -50'sd2147483648;

  function automatic logic [32:0] clamp50(input logic signed [49:0] v);
    if (v > WIDE_MAX) begin
      return {1'b1, vfa_pkg::Q_MAX};
    end else if (v < WIDE_MIN) begin
      return {1'b1, vfa_pkg::Q_MIN};
    end
    return {1'b0, v[31:0]};
  endfunction

  logic adv;

  // whole pipe moves together; the result register frees it
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---- multiply step ----
  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];
  logic               m_vld;
  vfa_pkg::item_t     m_item;
  logic signed [63:0] pm [6];
  logic signed [32:0] m_as [3];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (in_item.cls.op)
      vfa_pkg::OP_MUL, vfa_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = in_item.a[i];
          mb[i] = in_item.b[i];
        end
      end
      vfa_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = in_item.a[i];
          mb[i] = in_item.f;
        end
      end
      vfa_pkg::OP_CROSS: begin
        ma[0] = in_item.a[1]; mb[0] = in_item.b[2];
        ma[1] = in_item.a[2]; mb[1] = in_item.b[1];
        ma[2] = in_item.a[2]; mb[2] = in_item.b[0];
        ma[3] = in_item.a[0]; mb[3] = in_item.b[2];
        ma[4] = in_item.a[0]; mb[4] = in_item.b[1];
        ma[5] = in_item.a[1]; mb[5] = in_item.b[0];
      end
      vfa_pkg::OP_NORM, vfa_pkg::OP_LEN, vfa_pkg::OP_LENSQ: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = in_item.a[i];
          mb[i] = in_item.a[i];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_item <= in_item;
      for (int i = 0; i < 6; i++) begin
        pm[i] <= ma[i] * mb[i];
      end
      for (int i = 0; i < 3; i++) begin
        if (in_item.cls.op == vfa_pkg::OP_SUB) begin
          m_as[i] <= $signed({in_item.a[i][31], in_item.a[i]}) -
                     $signed({in_item.b[i][31], in_item.b[i]});
        end else begin
          m_as[i] <= $signed({in_item.a[i][31], in_item.a[i]}) +
                     $signed({in_item.b[i][31], in_item.b[i]});
        end
      end
    end
  end

  // ---- sum step: floor each product, combine exactly ----
  logic signed [47:0] fl [6];
  logic signed [49:0] w_next [3];
  logic signed [49:0] ws_next;
  logic [63:0]        sq_next;
  logic               s_vld;
  vfa_pkg::item_t     s_item;
  logic signed [49:0] w [3];
  logic signed [49:0] ws;
  logic [63:0]        sq;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      fl[i] = pm[i][63:16];
    end
    for (int i = 0; i < 3; i++) begin
      w_next[i] = '0;
    end
    ws_next = '0;
    sq_next = pm[0] + pm[1] + pm[2];
    case (m_item.cls.op)
      vfa_pkg::OP_ADD, vfa_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          w_next[i] = 50'(m_as[i]);
        end
      end
      vfa_pkg::OP_MUL, vfa_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          w_next[i] = 50'(fl[i]);
        end
      end
      vfa_pkg::OP_CROSS: begin
        w_next[0] = 50'(fl[0]) - 50'(fl[1]);
        w_next[1] = 50'(fl[2]) - 50'(fl[3]);
        w_next[2] = 50'(fl[4]) - 50'(fl[5]);
      end
      vfa_pkg::OP_DOT, vfa_pkg::OP_LENSQ: begin
        ws_next = 50'(fl[0]) + 50'(fl[1]) + 50'(fl[2]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (adv) begin
      s_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_item <= m_item;
      w      <= w_next;
      ws     <= ws_next;
      sq     <= sq_next;
    end
  end

  // ---- clamp step: finish the direct ops, set up root and divide ----
  vfa_pkg::side_t side_next;
  logic [32:0]    cl [3];
  logic [32:0]    cls_s;
  logic           c_vld;
  vfa_pkg::side_t c_side;
  logic [63:0]    c_sq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cl[i] = clamp50(w[i]);
    end
    cls_s = clamp50(ws);
    side_next.cls      = s_item.cls;
    side_next.byp.dz   = 1'b0;
    side_next.byp.sat  = cl[0][32] | cl[1][32] | cl[2][32] | cls_s[32];
    side_next.byp.s    = cls_s[31:0];
    side_next.fmag     = s_item.f[31] ? 32'(-s_item.f) : s_item.f;
    for (int i = 0; i < 3; i++) begin
      side_next.byp.r[i] = cl[i][31:0];
      side_next.nmag[i]  = s_item.a[i][31] ? 32'(-s_item.a[i]) : s_item.a[i];
      side_next.neg[i]   = s_item.a[i][31] ^
                           ((s_item.cls.op == vfa_pkg::OP_DIV) && s_item.f[31]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_side <= side_next;
      c_sq   <= sq;
    end
  end

  // ---- root and divide pipes ----
  logic           r_vld;
  logic [31:0]    r_root;
  vfa_pkg::side_t r_side;

  vfa_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (c_vld),
    .in_rad    (c_sq),
    .in_side   (c_side),
    .out_valid (r_vld),
    .out_root  (r_root),
    .out_side  (r_side)
  );

  logic            d_vld;
  logic [2:0][31:0] d_quo;
  logic [2:0]      d_big;
  vfa_pkg::dside_t d_side;

  vfa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (r_vld),
    .in_root   (r_root),
    .in_side   (r_side),
    .out_valid (d_vld),
    .out_quo   (d_quo),
    .out_big   (d_big),
    .out_side  (d_side)
  );

  // ---- result register ----
  vfa_pkg::res_t res_next;
  vfa_pkg::res_t res;
  logic          res_vld;

  always_comb begin
    res_next = d_side.byp;
    case (d_side.cls.op)
      vfa_pkg::OP_DIV, vfa_pkg::OP_NORM: begin
        res_next.s   = '0;
        res_next.sat = 1'b0;
        for (int l = 0; l < 3; l++) begin
          if (d_big[l]) begin
            res_next.r[l] = d_side.neg[l] ? vfa_pkg::Q_MIN : vfa_pkg::Q_MAX;
            res_next.sat  = 1'b1;
          end else if (!d_side.neg[l]) begin
            res_next.r[l] = d_quo[l][31] ? vfa_pkg::Q_MAX : d_quo[l];
            res_next.sat  = res_next.sat | d_quo[l][31];
          end else if (d_quo[l][31] && (d_quo[l][30:0] != '0)) begin
            res_next.r[l] = vfa_pkg::Q_MIN;
            res_next.sat  = 1'b1;
          end else begin
            res_next.r[l] = 32'(-d_quo[l]);
          end
        end
      end
      vfa_pkg::OP_LEN: begin
        res_next.s   = d_side.root[31] ? vfa_pkg::Q_MAX : d_side.root;
        res_next.sat = d_side.root[31];
      end
      default: begin
      end
    endcase
    // zero divisor or zero vector: drop everything, raise the flag
    if (d_side.cls.dz) begin
      res_next     = '0;
      res_next.dz  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (adv) begin
      res_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

  assign out_valid = res_vld;
  assign out_res   = res;

endmodule
`default_nettype wire
